// ===== hdl/array_list_insert_delete_assert.svh =====
// Assertion macros for the positional list block.
// Included by alid_ctrl and alid_dp; expects aclk and aresetn in scope.
`ifndef ARRAY_LIST_INSERT_DELETE_ASSERT_SVH
`define ARRAY_LIST_INSERT_DELETE_ASSERT_SVH

// condition holds at every clock edge out of reset
`define ALID_ASSERT_HOLDS(lbl, expr, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (expr)) \
        else $error(msg);

// consequent holds in the same cycle as the antecedent
`define ALID_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// consequent holds in the cycle after the antecedent
`define ALID_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/alid_pkg.sv =====
// Shared types and codes for the positional list block.
// Used by alid_ctrl, alid_dp and array_list_insert_delete; no dependencies.
package alid_pkg;

    localparam int KIND_W      = 3;
    localparam int POS_W       = 5;
    localparam int DATA_FIELD_W = 64;
    localparam int STAT_W      = 2;
    localparam int CNT_OUT_W   = 5;
    localparam int TDATA_W     = 72;

    localparam logic [KIND_W-1:0] KIND_INSERT    = 3'd0;
    localparam logic [KIND_W-1:0] KIND_DELETE    = 3'd1;
    localparam logic [KIND_W-1:0] KIND_READ      = 3'd2;
    localparam logic [KIND_W-1:0] KIND_OVERWRITE = 3'd3;
    localparam logic [KIND_W-1:0] KIND_CLEAR     = 3'd4;

    localparam logic [STAT_W-1:0] ST_OK     = 2'd0;
    localparam logic [STAT_W-1:0] ST_FULL   = 2'd1;
    localparam logic [STAT_W-1:0] ST_BADPOS = 2'd2;
    localparam logic [STAT_W-1:0] ST_EMPTY  = 2'd3;

    typedef struct packed {
        logic capture;
        logic init_idx;
        logic mem_rd;
        logic wr_shift;
        logic wr_word;
        logic commit;
    } cmd_t;

    typedef struct packed {
        logic is_ins;
        logic is_del;
        logic is_rd;
        logic is_ovw;
        logic ok;
        logic more;
    } sts_t;

endpackage

// ===== hdl/array_list_insert_delete.sv =====
// Top level of the positional list block: stream ports, controller and datapath.
// Depends on alid_pkg, alid_ctrl and alid_dp.
//
// Usage:
//   Slave channel s_*: one beat is one request. s_tuser carries req_type
//   (insert, delete, read, overwrite, clear all); s_tdata carries position
//   and entry_data. Master channel m_*: one result beat per request, with
//   status in m_tuser and read_data and element_count in m_tdata.
//   Requests are handled one at a time. For read, overwrite, clear and
//   rejected requests the controller passes through its evaluate and finish
//   states, then registers the result; m_tvalid rises in the same cycle that
//   s_tready returns. Insert moves count - position entries and delete moves
//   count - position - 1 entries: each moved entry costs one read and one
//   write on the single-read, single-write entry memory.
//   s_tready is high whenever no request is in progress, so the next request
//   is taken while an earlier result still waits on m_tready. A finished
//   request holds until the result register is free; a stalled result beat
//   holds its payload.
//   Reset empties the list (count zero, no result pending); entry contents
//   are not cleared and are only visible after being written.
module array_list_insert_delete #(
    parameter int CAPACITY   = 16,
    parameter int DATA_WIDTH = 64
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [alid_pkg::TDATA_W-1:0]   s_tdata,  // position[4:0], entry_data[68:5]
    input  logic [alid_pkg::KIND_W-1:0]    s_tuser,  // req_type[2:0]
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [alid_pkg::TDATA_W-1:0]   m_tdata,  // read_data[63:0], element_count[68:64]
    output logic [alid_pkg::STAT_W-1:0]    m_tuser   // status[1:0]
);
    import alid_pkg::*;

    cmd_t                    cmd;
    sts_t                    sts;
    logic [DATA_FIELD_W-1:0] read_data;
    logic [CNT_OUT_W-1:0]    element_count;

    alid_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    alid_dp #(
        .CAPACITY   (CAPACITY),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_dp (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .req_type      (s_tuser),
        .position      (s_tdata[POS_W-1:0]),
        .entry_data    (s_tdata[POS_W +: DATA_FIELD_W]),
        .cmd           (cmd),
        .sts           (sts),
        .status        (m_tuser),
        .read_data     (read_data),
        .element_count (element_count)
    );

    assign m_tdata = TDATA_W'({element_count, read_data});

endmodule

// ===== hdl/alid_ctrl.sv =====
// Sequencer for the positional list: accepts beats, steps shift loops, issues results.
// Depends on alid_pkg and array_list_insert_delete_assert.svh.
`include "array_list_insert_delete_assert.svh"

module alid_ctrl (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_tvalid,
    output logic          s_tready,
    output logic          m_tvalid,
    input  logic          m_tready,
    input  alid_pkg::sts_t sts,
    output alid_pkg::cmd_t cmd
);
    import alid_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EVAL,
        S_LOOP,
        S_WR,
        S_FIN
    } state_t;

    state_t state_reg, state_next;
    logic   m_valid_reg, m_valid_next;

    always_comb begin
        cmd          = '0;
        state_next   = state_reg;
        m_valid_next = m_valid_reg && !m_tready;
        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    cmd.capture = 1'b1;
                    state_next  = S_EVAL;
                end
            end
            S_EVAL: begin
                state_next = S_FIN;
                if (sts.ok) begin
                    if (sts.is_ins || sts.is_del) begin
                        cmd.init_idx = 1'b1;
                        state_next   = S_LOOP;
                    end else if (sts.is_rd) begin
                        cmd.mem_rd = 1'b1;
                    end else if (sts.is_ovw) begin
                        cmd.wr_word = 1'b1;
                    end
                end
            end
            S_LOOP: begin
                if (sts.more) begin
                    cmd.mem_rd = 1'b1;
                    state_next = S_WR;
                end else begin
                    cmd.wr_word = sts.is_ins;
                    state_next  = S_FIN;
                end
            end
            S_WR: begin
                cmd.wr_shift = 1'b1;
                state_next   = S_LOOP;
            end
            S_FIN: begin
                if (!m_valid_reg || m_tready) begin
                    cmd.commit   = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_valid_reg;

    `ALID_ASSERT_SAME(a_no_overwrite, cmd.commit, !m_valid_reg || m_tready, "result overwritten")
    `ALID_ASSERT_NEXT(a_rd_then_wr, (state_reg == S_LOOP) && sts.more, cmd.wr_shift, "shift write missing")
    `ALID_ASSERT_NEXT(a_commit_valid, cmd.commit, m_tvalid, "result not presented")

endmodule

// ===== hdl/alid_dp.sv =====
// Datapath for the positional list: request registers, entry memory, count, result registers.
// Depends on alid_pkg and array_list_insert_delete_assert.svh.
`include "array_list_insert_delete_assert.svh"

module alid_dp #(
    parameter int CAPACITY   = 16,
    parameter int DATA_WIDTH = 64
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic [alid_pkg::KIND_W-1:0]         req_type,
    input  logic [alid_pkg::POS_W-1:0]          position,
    input  logic [alid_pkg::DATA_FIELD_W-1:0]   entry_data,
    input  alid_pkg::cmd_t                      cmd,
    output alid_pkg::sts_t                      sts,
    output logic [alid_pkg::STAT_W-1:0]         status,
    output logic [alid_pkg::DATA_FIELD_W-1:0]   read_data,
    output logic [alid_pkg::CNT_OUT_W-1:0]      element_count
);
    import alid_pkg::*;

    localparam int ADDR_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W  = $clog2(CAPACITY + 1);
    localparam int CMP_W  = (CNT_W > POS_W) ? CNT_W : POS_W;

    logic [DATA_WIDTH-1:0]   entries_reg [CAPACITY];
    logic [KIND_W-1:0]       kind_reg;
    logic [POS_W-1:0]        pos_reg;
    logic [DATA_WIDTH-1:0]   word_reg;
    logic [ADDR_W-1:0]       idx_reg;
    logic [CNT_W-1:0]        count_reg, count_next;
    logic [DATA_WIDTH-1:0]   rd_data_reg;
    logic [STAT_W-1:0]       status_reg;
    logic [DATA_FIELD_W-1:0] rdata_reg;
    logic [CNT_OUT_W-1:0]    cnt_out_reg;

    logic [STAT_W-1:0] st_code;
    logic [CMP_W-1:0]  pos_x, cnt_x, idx_x, cnt_next_x;
    logic [ADDR_W-1:0] pos_addr, rd_addr;
    logic              is_clr;

    assign pos_x      = CMP_W'(pos_reg);
    assign cnt_x      = CMP_W'(count_reg);
    assign idx_x      = CMP_W'(idx_reg);
    assign pos_addr   = pos_x[ADDR_W-1:0];
    assign cnt_next_x = CMP_W'(count_next);

    always_comb begin
        st_code = ST_OK;
        unique case (kind_reg) inside
            KIND_INSERT: begin
                if (count_reg >= CNT_W'(CAPACITY)) begin
                    st_code = ST_FULL;
                end else if (pos_x > cnt_x) begin
                    st_code = ST_BADPOS;
                end
            end
            KIND_DELETE, KIND_READ, KIND_OVERWRITE: begin
                if (count_reg == '0) begin
                    st_code = ST_EMPTY;
                end else if (pos_x >= cnt_x) begin
                    st_code = ST_BADPOS;
                end
            end
            default: st_code = ST_OK;
        endcase
    end

    assign sts.is_ins = (kind_reg == KIND_INSERT);
    assign sts.is_del = (kind_reg == KIND_DELETE);
    assign sts.is_rd  = (kind_reg == KIND_READ);
    assign sts.is_ovw = (kind_reg == KIND_OVERWRITE);
    assign is_clr     = (kind_reg == KIND_CLEAR);
    assign sts.ok     = (st_code == ST_OK);
    assign sts.more   = sts.is_ins ? (idx_x != pos_x) :
                        sts.is_del ? ((idx_x + CMP_W'(1)) < cnt_x) : 1'b0;

    always_comb begin
        if (sts.is_rd) begin
            rd_addr = pos_addr;
        end else if (sts.is_ins) begin
            rd_addr = idx_reg - ADDR_W'(1);
        end else begin
            rd_addr = idx_reg + ADDR_W'(1);
        end
    end

    always_comb begin
        count_next = count_reg;
        if (is_clr) begin
            count_next = '0;
        end else if (sts.ok && sts.is_ins) begin
            count_next = count_reg + CNT_W'(1);
        end else if (sts.ok && sts.is_del) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    // request capture, shift index and read port
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            kind_reg <= req_type;
            pos_reg  <= position;
            word_reg <= entry_data[DATA_WIDTH-1:0];
        end
        if (cmd.init_idx) begin
            idx_reg <= sts.is_ins ? count_reg[ADDR_W-1:0] : pos_addr;
        end else if (cmd.wr_shift) begin
            idx_reg <= sts.is_ins ? idx_reg - ADDR_W'(1) : idx_reg + ADDR_W'(1);
        end
        if (cmd.mem_rd) begin
            rd_data_reg <= entries_reg[rd_addr];
        end
    end

    // write port
    always_ff @(posedge aclk) begin
        if (cmd.wr_shift) begin
            entries_reg[idx_reg] <= rd_data_reg;
        end else if (cmd.wr_word) begin
            entries_reg[pos_addr] <= word_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else if (cmd.commit) begin
            count_reg <= count_next;
        end
    end

    // result beat
    always_ff @(posedge aclk) begin
        if (cmd.commit) begin
            status_reg  <= st_code;
            rdata_reg   <= (sts.is_rd && sts.ok) ? DATA_FIELD_W'(rd_data_reg) : '0;
            cnt_out_reg <= cnt_next_x[CNT_OUT_W-1:0];
        end
    end

    assign status        = status_reg;
    assign read_data     = rdata_reg;
    assign element_count = cnt_out_reg;

    `ALID_ASSERT_HOLDS(a_cnt_max, count_reg <= CNT_W'(CAPACITY), "count above capacity")
    `ALID_ASSERT_SAME(a_shift_range, cmd.wr_shift, idx_x <= cnt_x, "shift write past count")
    `ALID_ASSERT_NEXT(a_cnt_hold, !cmd.commit, $stable(count_reg), "count moved without commit")

endmodule
